>>> hdl/aes_gcm_engine_top_defines.svh
// Assertion macros for the AES-GCM engine.
// Used by the modules that carry checks; no other dependencies.
`ifndef AES_GCM_ENGINE_TOP_DEFINES_SVH
`define AES_GCM_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTH
`define AGE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define AGE_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AGE_ASSERT(lbl, clk, rstn, prop, msg)
`define AGE_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/age_pkg.sv
// Shared types, codes and AES/GHASH helper functions for the AES-GCM engine.
// No dependencies.
package age_pkg;
  localparam logic [1:0] FUNC_AAD = 2'd0;
  localparam logic [1:0] FUNC_PAY = 2'd1;
  localparam logic [1:0] FUNC_FIN = 2'd2;
  localparam logic [1:0] FUNC_BAD = 2'd3;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_KSIZE = 3'd4;
  localparam logic [2:0] REG_NHI = 3'd5;
  localparam logic [2:0] REG_NLO = 3'd6;
  localparam logic [2:0] REG_DEC = 3'd7;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;

  localparam logic [1:0] PH_FRESH = 2'd0;
  localparam logic [1:0] PH_AAD = 2'd1;
  localparam logic [1:0] PH_PAY = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int RK_DEPTH = 15;
  localparam int RK_AW = 4;
  localparam int GH_BITS = 8;  // GHASH multiplier bits per cycle

  localparam logic [7:0] GHASH_R = 8'he1;

  // classified word handed from front to back
  typedef struct packed {
    logic [1:0]   func;
    logic         bad;
    logic         start;
    logic [127:0] data;
    logic [127:0] mask;
    logic [4:0]   nbytes;
  } cmd_t;

  typedef struct packed {
    logic [127:0] result;
    logic         tag_match;
    logic         status;
  } res_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block, byte 0 in the top bits
  function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
    return s[127 - 8 * i -: 8];
  endfunction

  // one AES round without the key add; last drops MixColumns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, e;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8 * (4 * c + r) -: 8] = sbox(byte_of(s, 4 * ((c + r) % 4) + r));
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = byte_of(t, 4 * c); a1 = byte_of(t, 4 * c + 1);
        a2 = byte_of(t, 4 * c + 2); a3 = byte_of(t, 4 * c + 3);
        e = a0 ^ a1 ^ a2 ^ a3;
        t[127 - 32 * c -: 32] = {a0 ^ e ^ xtime(a0 ^ a1), a1 ^ e ^ xtime(a1 ^ a2),
                                 a2 ^ e ^ xtime(a2 ^ a3), a3 ^ e ^ xtime(a3 ^ a0)};
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // byte mask for the first n bytes of a block
  function automatic logic [127:0] byte_mask(input logic [4:0] n);
    logic [127:0] m;
    for (int i = 0; i < 16; i++)
      m[127 - 8 * i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
    return m;
  endfunction
endpackage

>>> hdl/age_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module age_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/age_front.sv
// Front end: accepts input words, checks message order, queues commands.
// Depends on age_pkg and the assertion macros.
`include "aes_gcm_engine_top_defines.svh"
module age_front
  import age_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  func,
  input  logic [127:0] data,
  input  logic [4:0]  nbytes,
  output logic        cmd_valid,
  input  logic        cmd_take,
  output cmd_t        cmd
);
  localparam int QAW = $clog2(QUEUE_DEPTH);

  cmd_t q_r [QUEUE_DEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0] cnt_r, cnt_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic short_r, short_nxt;
  logic acc, bad, lenbad;
  cmd_t c;

  assign in_tready = (cnt_r != (QAW + 1)'(QUEUE_DEPTH));
  assign acc = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != '0);
  assign cmd = q_r[rp_r];

  // order tracking is done here, at accept time, so the back end never stalls
  // the front on a refusal
  always_comb begin
    lenbad = (nbytes == 5'd0) || (nbytes > 5'd16);
    bad = 1'b0;
    if (func == FUNC_BAD) bad = 1'b1;
    if (func != FUNC_FIN && func != FUNC_BAD && lenbad) bad = 1'b1;
    if (func == FUNC_AAD && (phase_r == PH_PAY || (phase_r == PH_AAD && short_r))) bad = 1'b1;
    if (func == FUNC_PAY && phase_r == PH_PAY && short_r) bad = 1'b1;
    c.func = func;
    c.bad = bad;
    c.start = (phase_r == PH_FRESH);
    c.mask = byte_mask(nbytes);
    // the expected tag of a finish word is taken whole
    c.data = (func == FUNC_FIN) ? data : (data & c.mask);
    c.nbytes = nbytes;
    phase_nxt = phase_r;
    short_nxt = short_r;
    if (acc && !bad) begin
      unique case (func)
        FUNC_FIN: begin phase_nxt = PH_FRESH; short_nxt = 1'b0; end
        FUNC_AAD: begin phase_nxt = PH_AAD; short_nxt = (nbytes < 5'd16); end
        default:  begin phase_nxt = PH_PAY; short_nxt = (nbytes < 5'd16); end
      endcase
    end
    wp_nxt = acc ? QAW'((wp_r + 1'b1) % QUEUE_DEPTH) : wp_r;
    rp_nxt = (cmd_valid && cmd_take) ? QAW'((rp_r + 1'b1) % QUEUE_DEPTH) : rp_r;
    cnt_nxt = cnt_r + (QAW + 1)'(acc) - (QAW + 1)'(cmd_valid && cmd_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
      phase_r <= PH_FRESH; short_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
      phase_r <= phase_nxt; short_r <= short_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) q_r[wp_r] <= c;
  end

  `AGE_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= (QAW + 1)'(QUEUE_DEPTH), "queue overfilled")
  `AGE_ASSERT(a_full_nrdy, clk, rst_n, (cnt_r == (QAW + 1)'(QUEUE_DEPTH)) |-> !in_tready, "ready while full")
  `AGE_ASSERT(a_fin_fresh, clk, rst_n, (acc && !bad && func == FUNC_FIN) |=> phase_r == PH_FRESH, "finish left phase")
endmodule

>>> hdl/age_back.sv
// Back end: key expansion, iterated AES round unit, digit-serial GHASH, result register.
// Depends on age_pkg, age_ram and the assertion macros.
`include "aes_gcm_engine_top_defines.svh"
module age_back
  import age_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_valid,
  output logic         cmd_take,
  input  cmd_t         cmd,
  input  logic [255:0] key,
  input  logic [1:0]   key_size,
  input  logic [95:0]  nonce,
  input  logic         dec,
  output logic         res_valid,
  input  logic         res_ready,
  output res_t         res
);
  localparam logic [3:0] S_IDLE = 4'd0, S_KEXP = 4'd1, S_ENC = 4'd2,
                         S_ENCW = 4'd3, S_GH = 4'd4, S_DONE = 4'd5,
                         S_H = 4'd6, S_J0 = 4'd7;
  localparam int GH_STEPS = 128 / GH_BITS;

  logic [3:0] st_r, st_nxt;
  logic [3:0] ret_r, ret_nxt;           // state after an encryption
  cmd_t c_r, c_nxt;
  logic [127:0] h_r, h_nxt, j0_r, j0_nxt, acc_r, acc_nxt, ks_r, ks_nxt;
  logic [127:0] s_r, s_nxt, blk_r, blk_nxt;
  logic [31:0] ctr_r, ctr_nxt;
  logic [63:0] alen_r, alen_nxt, dlen_r, dlen_nxt;
  logic [3:0] rounds_r, rounds_nxt, rnd_r, rnd_nxt;
  logic [2:0] nk_r, nk_nxt;
  logic [31:0] w_r [8];
  logic [31:0] w_nxt [8];
  logic [5:0] wi_r, wi_nxt;
  logic [2:0] wm_r, wm_nxt;             // wi mod nk
  logic [7:0] rc_r, rc_nxt;
  logic [127:0] rk_wbuf_r, rk_wbuf_nxt;
  logic [1:0] wc_r, wc_nxt;
  logic [127:0] z_r, z_nxt, v_r, v_nxt, x_r, x_nxt;
  logic [4:0] gs_r, gs_nxt;
  logic res_valid_r, res_valid_nxt;
  res_t res_r, res_nxt;
  logic rk_we;
  logic [RK_AW-1:0] rk_waddr, rk_waddr_r, rk_waddr_nxt, rk_raddr;
  logic [127:0] rk_rdata;
  logic [31:0] t;
  logic [127:0] z, v, out;
  logic [3:0] nrounds;

  age_ram #(.WIDTH(128), .DEPTH(RK_DEPTH)) u_rk (
    .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wbuf_nxt),
    .raddr(rk_raddr), .rdata(rk_rdata));

  assign res_valid = res_valid_r;
  assign res = res_r;
  assign cmd_take = (st_r == S_IDLE) && cmd_valid && !res_valid_r;
  assign rk_waddr = rk_waddr_r;

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; c_nxt = c_r;
    h_nxt = h_r; j0_nxt = j0_r; acc_nxt = acc_r; ks_nxt = ks_r;
    s_nxt = s_r; blk_nxt = blk_r; ctr_nxt = ctr_r;
    alen_nxt = alen_r; dlen_nxt = dlen_r;
    rounds_nxt = rounds_r; rnd_nxt = rnd_r; nk_nxt = nk_r;
    w_nxt = w_r; wi_nxt = wi_r; wm_nxt = wm_r; rc_nxt = rc_r;
    rk_wbuf_nxt = rk_wbuf_r; wc_nxt = wc_r; rk_we = 1'b0;
    rk_waddr_nxt = rk_waddr_r;
    z_nxt = z_r; v_nxt = v_r; x_nxt = x_r; gs_nxt = gs_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt = res_r;
    rk_raddr = rnd_r;
    t = '0; z = z_r; v = v_r; out = '0;
    nrounds = (key_size == KS_128) ? 4'd10 : (key_size == KS_192) ? 4'd12 : 4'd14;
    unique case (st_r)
      S_IDLE: begin
        if (cmd_take) begin
          c_nxt = cmd;
          if (cmd.bad) begin
            res_nxt = '{result: '0, tag_match: 1'b0, status: 1'b1};
            res_valid_nxt = 1'b1;
          end else if (cmd.start) begin
            // load all eight key words into the window; the first nk go out one 32-bit word per cycle in S_KEXP
            for (int i = 0; i < 8; i++) w_nxt[i] = key[255 - 32 * i -: 32];
            nk_nxt = (key_size == KS_128) ? 3'd4 : (key_size == KS_192) ? 3'd6 : 3'd0;
            rounds_nxt = nrounds;
            wi_nxt = '0; wm_nxt = '0; rc_nxt = 8'h01; wc_nxt = '0;
            rk_waddr_nxt = '0;
            st_nxt = S_KEXP;
          end else begin
            st_nxt = S_ENC; ret_nxt = S_GH;
          end
        end
      end
      S_KEXP: begin
        // w_r is a window of the last nk words (nk 0 encodes 8); w_r[0] oldest.
        // wi_r counts produced words. First nk words are the key itself.
        if (wi_r < 6'((nk_r == 3'd0) ? 8 : nk_r)) begin
          rk_wbuf_nxt = {rk_wbuf_r[95:0], w_r[wi_r[2:0]]};
        end else begin
          t = w_r[3'((nk_r == 3'd0 ? 8 : nk_r) - 1)];
          if (wm_r == 3'd0) begin
            t = sub_word({t[23:0], t[31:24]}) ^ {rc_r, 24'h0};
            rc_nxt = xtime(rc_r);
          end else if (nk_r == 3'd0 && wm_r == 3'd4) begin
            t = sub_word(t);
          end
          t = t ^ w_r[0];
          for (int i = 0; i < 7; i++) w_nxt[i] = w_r[i + 1];
          w_nxt[3'((nk_r == 3'd0 ? 8 : nk_r) - 1)] = t;
          rk_wbuf_nxt = {rk_wbuf_r[95:0], t};
        end
        if (wi_r >= 6'((nk_r == 3'd0) ? 8 : nk_r))
          wm_nxt = (wm_r == 3'((nk_r == 3'd0 ? 8 : nk_r) - 1)) ? 3'd0 : wm_r + 3'd1;
        else if (wi_r == 6'((nk_r == 3'd0 ? 8 : nk_r) - 1))
          wm_nxt = 3'd0;
        wi_nxt = wi_r + 6'd1;
        wc_nxt = wc_r + 2'd1;
        if (wc_r == 2'd3) begin
          rk_we = 1'b1;
          rk_waddr_nxt = rk_waddr_r + 4'd1;
          if (rk_waddr_r == rounds_r) begin
            s_nxt = '0; st_nxt = S_ENC; ret_nxt = S_H;
          end
        end
      end
      S_ENC: begin
        // block to encrypt chosen by the return state
        if (ret_r == S_H) blk_nxt = '0;
        else if (ret_r == S_J0) blk_nxt = {nonce, 32'd1};
        else if (c_r.func == FUNC_PAY) blk_nxt = {nonce, ctr_r + 32'd1};
        rnd_nxt = '0;
        if (ret_r == S_GH && c_r.func != FUNC_PAY) begin
          st_nxt = S_GH;
          if (c_r.func == FUNC_FIN) x_nxt = acc_r ^ {alen_r, dlen_r};
          else x_nxt = acc_r ^ c_r.data;
          z_nxt = '0; v_nxt = h_r; gs_nxt = '0;
        end else begin
          st_nxt = S_ENCW;
          rk_raddr = '0;
        end
      end
      S_ENCW: begin
        // rnd_r: index of the round key whose data is on rk_rdata this cycle; the next key is addressed now
        rk_raddr = rnd_r + 4'd1;
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'd0) s_nxt = blk_r ^ rk_rdata;
        else s_nxt = aes_round(s_r, rnd_r == rounds_r) ^ rk_rdata;
        if (rnd_r == rounds_r) begin
          unique case (ret_r)
            S_H: begin
              h_nxt = aes_round(s_r, 1'b1) ^ rk_rdata;
              st_nxt = S_ENC; ret_nxt = S_J0;
            end
            S_J0: begin
              j0_nxt = aes_round(s_r, 1'b1) ^ rk_rdata;
              ctr_nxt = 32'd1; acc_nxt = '0; alen_nxt = '0; dlen_nxt = '0;
              st_nxt = S_ENC; ret_nxt = S_GH;
            end
            default: begin
              ks_nxt = (aes_round(s_r, 1'b1) ^ rk_rdata) ^ c_r.data;
              ks_nxt = ks_nxt & c_r.mask;
              ctr_nxt = ctr_r + 32'd1;
              x_nxt = acc_r ^ (dec ? c_r.data : ks_nxt);
              z_nxt = '0; v_nxt = h_r; gs_nxt = '0;
              st_nxt = S_GH;
            end
          endcase
        end
      end
      S_GH: begin
        // GH_BITS multiplier bits per cycle
        for (int i = 0; i < GH_BITS; i++) begin
          if (x_r[127 - i]) z = z ^ v;
          v = {1'b0, v[127:1]} ^ (v[0] ? {GHASH_R, 120'h0} : 128'h0);
        end
        z_nxt = z; v_nxt = v;
        x_nxt = x_r << GH_BITS;
        gs_nxt = gs_r + 5'd1;
        if (gs_r == 5'(GH_STEPS - 1)) begin
          acc_nxt = z;
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid_r || res_ready) begin
          unique case (c_r.func)
            FUNC_AAD: begin
              out = '0;
              alen_nxt = alen_r + {56'h0, c_r.nbytes, 3'b000};
              res_nxt = '{result: out, tag_match: 1'b0, status: 1'b0};
            end
            FUNC_PAY: begin
              dlen_nxt = dlen_r + {56'h0, c_r.nbytes, 3'b000};
              res_nxt = '{result: ks_r, tag_match: 1'b0, status: 1'b0};
            end
            default: begin
              out = acc_r ^ j0_r;
              res_nxt = '{result: out, tag_match: dec && (out == c_r.data),
                          status: 1'b0};
            end
          endcase
          res_valid_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ret_r <= S_GH; res_valid_r <= 1'b0;
      h_r <= '0; j0_r <= '0; acc_r <= '0; ctr_r <= '0;
      alen_r <= '0; dlen_r <= '0; rounds_r <= 4'd10;
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt; res_valid_r <= res_valid_nxt;
      h_r <= h_nxt; j0_r <= j0_nxt; acc_r <= acc_nxt; ctr_r <= ctr_nxt;
      alen_r <= alen_nxt; dlen_r <= dlen_nxt; rounds_r <= rounds_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt; ks_r <= ks_nxt; s_r <= s_nxt; blk_r <= blk_nxt;
    rnd_r <= rnd_nxt; nk_r <= nk_nxt; w_r <= w_nxt; wi_r <= wi_nxt;
    wm_r <= wm_nxt; rc_r <= rc_nxt; rk_wbuf_r <= rk_wbuf_nxt; wc_r <= wc_nxt;
    rk_waddr_r <= rk_waddr_nxt; z_r <= z_nxt; v_r <= v_nxt; x_r <= x_nxt;
    gs_r <= gs_nxt; res_r <= res_nxt;
  end

  `AGE_ASSERT(a_take_idle, clk, rst_n, cmd_take |-> st_r == S_IDLE, "take while busy")
  `AGE_ASSERT(a_res_hold, clk, rst_n, (res_valid_r && !res_ready) |=> res_valid_r, "result dropped")
  `AGE_ASSERT(a_done_leave, clk, rst_n, (st_r == S_DONE && !res_valid_r) |=> st_r == S_IDLE, "stuck in done")
endmodule

>>> hdl/aes_gcm_engine_top.sv
// AES-GCM engine top level: configuration registers, front and back ends.
// Depends on age_pkg, age_front, age_back and the assertion macros.
//
// AES-GCM for 128/192/256-bit keys and a 96-bit nonce, one 16-byte chunk per
// word. The front end checks message order at accept time and queues up to
// two words; the back end works on one word at a time. A word that starts a
// message first expands the key a 32-bit word at a time, writing a round key
// to the RAM for every four words, then runs E(0) and E(J0) through the round
// unit. After that, an AAD word is taken, set up, run through GHASH (8 bits
// per cycle) and its result registered; a payload word first takes an AES
// pass for its key stream; a finish word goes through GHASH like an AAD word.
// The AES round unit and the GHASH multiplier set the rate. Refused words
// (status 1) leave all state unchanged. Key and key size are taken at message
// start; nonce and decrypt mode are read live. Write configuration only while
// idle.
`include "aes_gcm_engine_top_defines.svh"
module aes_gcm_engine_top
  import age_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,  // data_hi[63:0], data_lo[127:64], byte_count[132:128], 0
  input  logic [1:0]   in_tuser,  // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata, // result_hi[63:0], result_lo[127:64]
  output logic [1:0]   out_tuser, // tag_match[0], status[1]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  logic [63:0] key_r [4];
  logic [1:0]  ksize_r;
  logic [63:0] nhi_r;
  logic [31:0] nlo_r;
  logic        dec_r;
  logic        cmd_valid, cmd_take;
  cmd_t        cmd;
  res_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      ksize_r <= '0; nhi_r <= '0; nlo_r <= '0; dec_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY0:  key_r[0] <= cfg_data;
        REG_KEY1:  key_r[1] <= cfg_data;
        REG_KEY2:  key_r[2] <= cfg_data;
        REG_KEY3:  key_r[3] <= cfg_data;
        REG_KSIZE: ksize_r <= cfg_data[1:0];
        REG_NHI:   nhi_r <= cfg_data;
        REG_NLO:   nlo_r <= cfg_data[31:0];
        REG_DEC:   dec_r <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  age_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .func(in_tuser), .data({in_tdata[63:0], in_tdata[127:64]}),
    .nbytes(in_tdata[132:128]),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd));

  age_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd(cmd), .key({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .key_size(ksize_r), .nonce({nhi_r, nlo_r}), .dec(dec_r),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res));

  assign out_tdata = {res.result[63:0], res.result[127:64]};
  assign out_tuser = {res.status, res.tag_match};

  `AGE_ASSERT(a_err_zero, clk, rst_n, (out_tvalid && out_tuser[1]) |-> (out_tdata == '0), "error result not zero")
  `AGE_ASSERT(a_err_nomatch, clk, rst_n, (out_tvalid && out_tuser[1]) |-> !out_tuser[0], "error with match")
  `AGE_ASSERT_RST(a_rst_quiet, clk, !rst_n |=> !out_tvalid, "valid after reset")
endmodule
